// ===== rtl/gcdh_pkg.sv =====
// Shared types, item codes and helpers for the grid cell density histogram.
// No dependencies; every rtl file of the block imports this package.
package gcdh_pkg;

	// Item kinds on the input channel
	localparam logic [2:0] KIND_MAP    = 3'd0;
	localparam logic [2:0] KIND_REGION = 3'd1;
	localparam logic [2:0] KIND_POINT  = 3'd2;
	localparam logic [2:0] KIND_END    = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_GRID_W  = 2'd0;
	localparam logic [1:0] CFG_GRID_H  = 2'd1;
	localparam logic [1:0] CFG_ALIVE   = 2'd2;

	// Field widths fixed by the item format
	localparam int ID_W     = 13;
	localparam int REGION_W = 8;
	localparam int COUNT_W  = 16;

	localparam logic [COUNT_W-1:0] SAT_MAX = '1;

	// Command from the controller to the region accumulator
	typedef struct packed {
		logic                inc;
		logic                clear;
		logic [REGION_W-1:0] mask;
	} acc_cmd_t;

	// Saturating increment of a count
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == SAT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== rtl/grid_cell_density_histogram_top.sv =====
// Grid cell density histogram: bins fixed-point points into map cells and
// keeps per-cell, per-region and total counts. Every item passes through a
// grid map read and then a read-modify-write of the cell table (both
// single-port RAMs with registered read data), and the next may be accepted
// as the previous finishes. A cell read also needs the output register free;
// an end-of-iteration item then emits MAX_REGIONS+1 beats, one per cycle while
// the sink takes them, before the next item is accepted. After reset the block
// sweeps and clears every cell table entry and takes no items during that
// pass; configuration writes are taken at any time. Depends on gcdh_pkg,
// gcdh_map_ram, gcdh_cell_ram and gcdh_region_acc.
module grid_cell_density_histogram_top #(
	parameter int MAX_GRID_W  = 128,
	parameter int MAX_GRID_H  = 128,
	parameter int MAX_CELLS   = 4096,
	parameter int MAX_REGIONS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic [3:0]         life_state,
	input  logic [13:0]        grid_index,
	input  logic [12:0]        cell_id,
	input  logic [7:0]         region_mask,
	// results
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         slot,
	output logic [15:0]        value,
	output logic               from_cell,
	output logic               last
);
	import gcdh_pkg::*;

	localparam int MapDepth = MAX_GRID_W * MAX_GRID_H;
	localparam int MapAw    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
	localparam int CellAw   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int EmitW    = $clog2(MAX_REGIONS + 1);
	localparam logic [10:0] GwMax = 11'(MAX_GRID_W);
	localparam logic [10:0] GhMax = 11'(MAX_GRID_H);

	// Controller states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]          state_q, state_d;

	// configuration registers
	logic [7:0]          grid_width_q;
	logic [7:0]          grid_height_q;
	logic [15:0]         alive_mask_q;

	// item registers
	logic [2:0]          kind_q;
	logic [ID_W-1:0]     cell_id_q;
	logic [REGION_W-1:0] region_mask_q;
	logic                pt_ok_q;
	logic [CellAw-1:0]   caddr_q;
	logic                cok_q;
	logic [CellAw-1:0]   clr_addr_q;
	logic [EmitW-1:0]    emit_idx_q;

	// output register
	logic                out_valid_q;
	logic [3:0]          slot_q;
	logic [COUNT_W-1:0]  value_q;
	logic                from_cell_q;
	logic                last_q;

	// accept-cycle decode
	logic                in_fire;
	logic [10:0]         gw_eff, gh_eff;
	logic                pt_inside;
	logic                map_we;
	logic [MapAw-1:0]    map_rd_addr, map_addr;
	logic [ID_W-1:0]     map_rdata;

	// cell table access
	logic [ID_W-1:0]     look_id;
	logic                look_ok;
	logic [CellAw-1:0]   look_addr;
	logic [CellAw-1:0]   cell_addr;
	logic                cell_we_reg, cell_we_cnt;
	logic [REGION_W-1:0] cell_wreg;
	logic [COUNT_W-1:0]  cell_wcnt;
	logic [REGION_W-1:0] cell_rreg;
	logic [COUNT_W-1:0]  cell_rcnt;

	// completion and output
	logic                out_free;
	logic                upd_done, upd_fire;
	logic                emit_last;
	logic                out_load;
	logic [3:0]          out_slot_d;
	logic [COUNT_W-1:0]  out_value_d;
	logic                out_from_cell_d, out_last_d;
	acc_cmd_t            acc_cmd;
	logic [COUNT_W-1:0]  acc_rd_value;

	// Configuration writes are always taken; unknown indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 8'd128;
			grid_height_q <= 8'd128;
			alive_mask_q  <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_W: grid_width_q  <= cfg_data[7:0];
				CFG_GRID_H: grid_height_q <= cfg_data[7:0];
				CFG_ALIVE:  alive_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: a new item enters from idle or as the previous one retires
	assign out_free  = !out_valid_q || out_ready;
	assign upd_done  = (kind_q != KIND_READ) || out_free;
	assign upd_fire  = (state_q == ST_UPD) && upd_done;
	assign in_ready  = (state_q == ST_IDLE) || (upd_fire && (kind_q != KIND_END));
	assign in_fire   = in_valid && in_ready;

	// Point qualification: alive, non-negative, inside the clamped grid
	assign gw_eff = (11'(grid_width_q) > GwMax) ? GwMax : 11'(grid_width_q);
	assign gh_eff = (11'(grid_height_q) > GhMax) ? GhMax : 11'(grid_height_q);
	assign pt_inside = alive_mask_q[life_state] && !x_coord[15] && !y_coord[15]
		&& (11'(x_coord[15:8]) < gw_eff) && (11'(y_coord[15:8]) < gh_eff);

	// Map port: write for a map load, otherwise read the point's entry
	assign map_rd_addr = MapAw'(32'(y_coord[15:8]) * 32'(MAX_GRID_W) + 32'(x_coord[15:8]));
	assign map_we      = in_fire && (kind == KIND_MAP) && (32'(grid_index) < 32'(MapDepth));
	assign map_addr    = (kind == KIND_MAP) ? MapAw'(grid_index) : map_rd_addr;

	gcdh_map_ram #(
		.DEPTH(MapDepth),
		.AW   (MapAw)
	) u_map (
		.clk  (clk),
		.addr (map_addr),
		.we   (map_we),
		.wdata(cell_id),
		.rdata(map_rdata)
	);

	// Hold the item fields for the later cycles
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q        <= kind;
			cell_id_q     <= cell_id;
			region_mask_q <= region_mask;
			pt_ok_q       <= (kind == KIND_POINT) && pt_inside;
		end
	end

	// Cell lookup: point takes its id from the map, others from the item
	always_comb begin
		if (kind_q == KIND_POINT) begin
			look_id = pt_ok_q ? map_rdata : '0;
		end else begin
			look_id = cell_id_q;
		end
		look_ok   = (look_id != '0) && (32'(look_id) <= MAX_CELLS);
		look_addr = CellAw'(look_id - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			caddr_q <= look_addr;
			cok_q   <= look_ok;
		end
	end

	// Cell table port: clear sweep, lookup read, or writeback
	always_comb begin
		cell_addr   = caddr_q;
		cell_we_reg = 1'b0;
		cell_we_cnt = 1'b0;
		cell_wreg   = region_mask_q;
		cell_wcnt   = '0;
		case (state_q)
			ST_CLR: begin
				cell_addr   = clr_addr_q;
				cell_we_reg = 1'b1;
				cell_we_cnt = 1'b1;
				cell_wreg   = '0;
			end
			ST_LOOK: begin
				cell_addr = look_addr;
			end
			ST_UPD: begin
				cell_we_reg = upd_fire && cok_q && (kind_q == KIND_REGION);
				cell_we_cnt = upd_fire && cok_q
					&& ((kind_q == KIND_READ) || ((kind_q == KIND_POINT) && pt_ok_q));
				cell_wcnt   = (kind_q == KIND_POINT) ? sat_inc(cell_rcnt) : '0;
			end
			default: ;
		endcase
	end

	gcdh_cell_ram #(
		.DEPTH(MAX_CELLS),
		.AW   (CellAw)
	) u_cell (
		.clk      (clk),
		.addr     (cell_addr),
		.we_reg   (cell_we_reg),
		.we_cnt   (cell_we_cnt),
		.wdata_reg(cell_wreg),
		.wdata_cnt(cell_wcnt),
		.rdata_reg(cell_rreg),
		.rdata_cnt(cell_rcnt)
	);

	// Region accumulator: bump on a counted point, clear with the final beat
	assign emit_last = (32'(emit_idx_q) == MAX_REGIONS);

	always_comb begin
		acc_cmd.inc   = upd_fire && (kind_q == KIND_POINT) && pt_ok_q && cok_q;
		acc_cmd.clear = (state_q == ST_EMIT) && out_free && emit_last;
		acc_cmd.mask  = cell_rreg;
	end

	gcdh_region_acc #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (acc_cmd),
		.rd_sel  (emit_idx_q),
		.rd_value(acc_rd_value)
	);

	// Result beat: cell read from writeback, sums from the emit sequence
	always_comb begin
		out_load        = 1'b0;
		out_slot_d      = 4'(emit_idx_q);
		out_value_d     = acc_rd_value;
		out_from_cell_d = 1'b0;
		out_last_d      = emit_last;
		if (state_q == ST_UPD && kind_q == KIND_READ) begin
			out_load        = upd_fire;
			out_slot_d      = '0;
			out_value_d     = cok_q ? cell_rcnt : '0;
			out_from_cell_d = 1'b1;
			out_last_d      = 1'b1;
		end else if (state_q == ST_EMIT) begin
			out_load = out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q      <= out_slot_d;
			value_q     <= out_value_d;
			from_cell_q <= out_from_cell_d;
			last_q      <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign value     = value_q;
	assign from_cell = from_cell_q;
	assign last      = last_q;

	// Sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_addr_q == CellAw'(MAX_CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: state_d = ST_UPD;
			ST_UPD: begin
				if (upd_fire) begin
					if (kind_q == KIND_END) begin
						state_d = ST_EMIT;
					end else if (in_fire) begin
						state_d = ST_LOOK;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (out_free && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
			emit_idx_q <= '0;
		end else begin
			state_q <= state_d;
			// advance the clear sweep
			if (state_q == ST_CLR) begin
				clr_addr_q <= CellAw'(clr_addr_q + 1'b1);
			end
			// step through the sums, restart for the next iteration
			if (state_q == ST_EMIT) begin
				if (out_free) begin
					emit_idx_q <= emit_last ? '0 : EmitW'(emit_idx_q + 1'b1);
				end
			end else begin
				emit_idx_q <= '0;
			end
		end
	end

	// No item enters during the clear sweep or the emit sequence
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR || state_q == ST_EMIT) |-> !in_ready)
		else $error("item accepted while clearing or emitting");

	// Cell table is written only in the clear sweep or at writeback
	a_cell_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_we_reg || cell_we_cnt) |-> (state_q == ST_CLR || state_q == ST_UPD))
		else $error("cell table written outside clear or writeback");

	// Sums are cleared only together with the final beat of the iteration
	a_clear_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cmd.clear |-> (out_load && out_last_d && !out_from_cell_d))
		else $error("region sums cleared without the final beat");

	// An end-of-iteration item always moves on to the emit sequence
	a_end_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && kind_q == KIND_END) |=> (state_q == ST_EMIT))
		else $error("end of iteration did not start emission");

	// A result beat is loaded only into a free output register
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

endmodule

// ===== rtl/gcdh_map_ram.sv =====
// Grid-to-cell map: single-port synchronous RAM, registered read data.
// Depends on gcdh_pkg for the cell id width.
module gcdh_map_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                    clk,
	input  logic [AW-1:0]           addr,
	input  logic                    we,
	input  logic [gcdh_pkg::ID_W-1:0] wdata,
	output logic [gcdh_pkg::ID_W-1:0] rdata
);
	import gcdh_pkg::*;

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rdata_q;

	// Write one entry, read one entry a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gcdh_cell_ram.sv =====
// Per-cell table: region mask and saturated count in one word, single port,
// separate write enables for the two fields. Depends on gcdh_pkg.
module gcdh_cell_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                          clk,
	input  logic [AW-1:0]                 addr,
	input  logic                          we_reg,
	input  logic                          we_cnt,
	input  logic [gcdh_pkg::REGION_W-1:0] wdata_reg,
	input  logic [gcdh_pkg::COUNT_W-1:0]  wdata_cnt,
	output logic [gcdh_pkg::REGION_W-1:0] rdata_reg,
	output logic [gcdh_pkg::COUNT_W-1:0]  rdata_cnt
);
	import gcdh_pkg::*;

	localparam int WORD_W = REGION_W + COUNT_W;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Field-enabled write, registered read
	always_ff @(posedge clk) begin
		if (we_reg) begin
			mem_q[addr][WORD_W-1:COUNT_W] <= wdata_reg;
		end
		if (we_cnt) begin
			mem_q[addr][COUNT_W-1:0] <= wdata_cnt;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata_reg = rdata_q[WORD_W-1:COUNT_W];
	assign rdata_cnt = rdata_q[COUNT_W-1:0];

endmodule

// ===== rtl/gcdh_region_acc.sv =====
// Region sums and the all-regions total, with readback for the end-of-iteration
// beats. Depends on gcdh_pkg for acc_cmd_t and sat_inc.
module gcdh_region_acc #(
	parameter int MAX_REGIONS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gcdh_pkg::acc_cmd_t                 cmd,
	input  logic [$clog2(MAX_REGIONS+1)-1:0]   rd_sel,
	output logic [gcdh_pkg::COUNT_W-1:0]       rd_value
);
	import gcdh_pkg::*;

	localparam int SelW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	// Mask bits that can reach a region: below MAX_REGIONS and inside the 8-bit mask
	localparam logic [15:0] LiveBits =
		16'((32'd1 << MAX_REGIONS) - 32'd1) & 16'h00FF;

	logic [COUNT_W-1:0] sums_q [MAX_REGIONS];
	logic [COUNT_W-1:0] total_q;
	logic [15:0]        mask_w;
	logic               any_region;

	assign mask_w     = 16'(cmd.mask) & LiveBits;
	assign any_region = |mask_w;

	// Bump every region in the mask, and the total once if any is hit; clear after readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_REGIONS; r++) begin
				sums_q[r] <= '0;
			end
			total_q <= '0;
		end else if (cmd.clear) begin
			for (int r = 0; r < MAX_REGIONS; r++) begin
				sums_q[r] <= '0;
			end
			total_q <= '0;
		end else if (cmd.inc) begin
			for (int r = 0; r < MAX_REGIONS; r++) begin
				if (mask_w[r]) begin
					sums_q[r] <= sat_inc(sums_q[r]);
				end
			end
			if (any_region) begin
				total_q <= sat_inc(total_q);
			end
		end
	end

	// Select a region sum or, past the last region, the total
	assign rd_value = (32'(rd_sel) < MAX_REGIONS) ? sums_q[SelW'(rd_sel)] : total_q;

endmodule
